/* hdl/ptc_pkg.sv */
`timescale 1ns / 1ps
// ptc_pkg: shared widths, constants and register index codes for the
// pressure and temperature compensation pipeline; no dependencies

package ptc_pkg;

  // field widths
  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int PRESS_W = 32;
  localparam int TEMP_W  = 19;
  localparam int IDX_W   = 3;

  // pipeline depth, one register set per stage
  localparam int NUM_STAGES = 11;

  // reference temperature and saturation bounds, 21-bit signed domain
  localparam logic signed [20:0] TEMP_REF = 21'sd2000;
  localparam logic signed [20:0] TEMP_MIN = -21'sd262144;
  localparam logic signed [20:0] TEMP_MAX = 21'sd262143;

  // floor(m / 10) = (m * RECIP_TEN) >> RECIP_SHIFT for m below 2^32
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SENS_COEFF        = 3'd0,
    REG_OFFSET_COEFF      = 3'd1,
    REG_SENS_TEMP_COEFF   = 3'd2,
    REG_OFFSET_TEMP_COEFF = 3'd3,
    REG_REFERENCE_TEMP    = 3'd4,
    REG_TEMP_SENSITIVITY  = 3'd5
  } ptc_reg_t;

endpackage

/* hdl/ptc_in_if.sv */
`timescale 1ns / 1ps
// ptc_in_if: valid/ready channel carrying one raw conversion pair
// depends on ptc_pkg for field widths

interface ptc_in_if;
  import ptc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

/* hdl/ptc_out_if.sv */
`timescale 1ns / 1ps
// ptc_out_if: valid/ready channel carrying one compensated result
// depends on ptc_pkg for field widths

interface ptc_out_if;
  import ptc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [PRESS_W-1:0] pressure;
  logic signed [TEMP_W-1:0]  temperature_centi;

  modport source (output valid, output pressure, output temperature_centi, input ready);
  modport sink   (input valid, input pressure, input temperature_centi, output ready);
endinterface

/* hdl/pressure_temp_compensation.sv */
`timescale 1ns / 1ps
// pressure_temp_compensation: pipelined second-order pressure and temperature
// compensation; depends on ptc_pkg, ptc_in_if and ptc_out_if

// Takes one transfer per clock on the sample channel while the result side
// does not stall and delivers one result per transfer on the result channel,
// in order. The eleven register stages carry their own valid bits and a
// ready chain, so a stall on the result side fills empty stages first and
// the sample side keeps taking transfers until every stage is occupied. The
// six calibration words are written through cfg_write/cfg_index/cfg_data and
// must only change while no sample is in flight; indexes six and seven are
// ignored. Pressure is ((D1*SENS/2^21 - OFF)/2^12)/10 with truncating
// divisions, temperature is in hundredths of a degree, saturated to 19 bits.

module pressure_temp_compensation import ptc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0] cfg_data,
  ptc_in_if.sink            sample,
  ptc_out_if.source         result
);

  // calibration registers
  logic [COEF_W-1:0] sens_coeff;
  logic [COEF_W-1:0] offset_coeff;
  logic [COEF_W-1:0] sens_temp_coeff;
  logic [COEF_W-1:0] offset_temp_coeff;
  logic [COEF_W-1:0] reference_temp;
  logic [COEF_W-1:0] temp_sensitivity;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_coeff        <= '0;
      offset_coeff      <= '0;
      sens_temp_coeff   <= '0;
      offset_temp_coeff <= '0;
      reference_temp    <= '0;
      temp_sensitivity  <= '0;
    end else if (cfg_write) begin
      unique case (ptc_reg_t'(cfg_index))
        REG_SENS_COEFF:        sens_coeff        <= cfg_data;
        REG_OFFSET_COEFF:      offset_coeff      <= cfg_data;
        REG_SENS_TEMP_COEFF:   sens_temp_coeff   <= cfg_data;
        REG_OFFSET_TEMP_COEFF: offset_temp_coeff <= cfg_data;
        REG_REFERENCE_TEMP:    reference_temp    <= cfg_data;
        REG_TEMP_SENSITIVITY:  temp_sensitivity  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage advance chain
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;
  logic                  in_xfer;
  logic                  out_xfer;

  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || result.ready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      adv[s] = !vld[s] || adv[s+1];
    end
  end

  assign sample.ready = adv[0];
  assign in_xfer      = sample.valid && sample.ready;
  assign out_xfer     = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= sample.valid;
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (adv[s]) vld[s] <= vld[s-1];
      end
    end
  end

  // stage 0: temperature difference dT
  logic [RAW_W-1:0]  d1_0;
  logic signed [24:0] dt_0;
  logic signed [24:0] dt_next;

  assign dt_next = $signed({1'b0, sample.raw_temperature})
                 - $signed({1'b0, reference_temp, 8'b0});

  // stage 1: products of dT
  logic [RAW_W-1:0]   d1_1;
  logic signed [41:0] prod_t_1;
  logic signed [41:0] prod_o_1;
  logic signed [41:0] prod_s_1;
  logic [47:0]        dtsq_1;
  logic signed [16:0] c6_s;
  logic signed [16:0] c4_s;
  logic signed [16:0] c3_s;
  logic signed [41:0] prod_t_next;
  logic signed [41:0] prod_o_next;
  logic signed [41:0] prod_s_next;
  logic signed [49:0] dtsq_full;

  assign c6_s        = $signed({1'b0, temp_sensitivity});
  assign c4_s        = $signed({1'b0, offset_temp_coeff});
  assign c3_s        = $signed({1'b0, sens_temp_coeff});
  assign prod_t_next = dt_0 * c6_s;
  assign prod_o_next = dt_0 * c4_s;
  assign prod_s_next = dt_0 * c3_s;
  assign dtsq_full   = dt_0 * dt_0;

  // stage 2: first-order TEMP offset, OFF, SENS and T2
  logic [RAW_W-1:0]   d1_2;
  logic signed [17:0] q_2;
  logic signed [35:0] off_2;
  logic signed [35:0] sens_2;
  logic [18:0]        t2_2;
  logic signed [41:0] tq_sum;
  logic signed [41:0] tq;
  logic signed [41:0] oq_sum;
  logic signed [41:0] oq;
  logic signed [41:0] sq_sum;
  logic signed [41:0] sq;
  logic signed [17:0] q_next;
  logic signed [35:0] off_next;
  logic signed [35:0] sens_next;
  logic [49:0]        three_sq;
  logic [18:0]        t2_next;

  always_comb begin
    // truncating divisions: bias negative values before the shift
    tq_sum    = prod_t_1 + (prod_t_1[41] ? 42'sd8388607 : 42'sd0);
    tq        = tq_sum >>> 23;
    oq_sum    = prod_o_1 + (prod_o_1[41] ? 42'sd127 : 42'sd0);
    oq        = oq_sum >>> 7;
    sq_sum    = prod_s_1 + (prod_s_1[41] ? 42'sd255 : 42'sd0);
    sq        = sq_sum >>> 8;
    q_next    = tq[17:0];
    off_next  = $signed({4'b0, offset_coeff, 16'b0}) + $signed(oq[35:0]);
    sens_next = $signed({5'b0, sens_coeff, 15'b0}) + $signed(sq[35:0]);
    // low branch uses 3*dT^2/2^31, high branch 2*dT^2/2^37
    three_sq  = {2'b0, dtsq_1} + {1'b0, dtsq_1, 1'b0};
    t2_next   = q_next[17] ? three_sq[49:31] : {7'b0, dtsq_1[47:36]};
  end

  // stage 3: squared temperature difference and final temperature
  logic [RAW_W-1:0]   d1_3;
  logic               neg_3;
  logic [33:0]        aux_3;
  logic signed [35:0] off_3;
  logic signed [35:0] sens_3;
  logic signed [TEMP_W-1:0] temp_3;
  logic signed [35:0] aux_full;
  logic signed [20:0] temp_full;
  logic signed [TEMP_W-1:0] temp_next;

  assign aux_full = q_2 * q_2;

  always_comb begin
    temp_full = TEMP_REF + 21'(q_2) - $signed({2'b0, t2_2});
    priority if (temp_full < TEMP_MIN) begin
      temp_next = TEMP_MIN[TEMP_W-1:0];
    end else if (temp_full > TEMP_MAX) begin
      temp_next = TEMP_MAX[TEMP_W-1:0];
    end else begin
      temp_next = temp_full[TEMP_W-1:0];
    end
  end

  // stage 4: second-order OFF and SENS corrections
  logic [RAW_W-1:0]   d1_4;
  logic signed [37:0] off_4;
  logic signed [36:0] sens_4;
  logic signed [TEMP_W-1:0] temp_4;
  logic [35:0]        three_aux;
  logic [36:0]        five_aux;
  logic [34:0]        off2;
  logic [33:0]        sens2;
  logic signed [37:0] off_c_next;
  logic signed [36:0] sens_c_next;

  always_comb begin
    three_aux   = {2'b0, aux_3} + {1'b0, aux_3, 1'b0};
    five_aux    = {3'b0, aux_3} + {1'b0, aux_3, 2'b0};
    off2        = neg_3 ? three_aux[35:1] : {5'b0, aux_3[33:4]};
    sens2       = neg_3 ? five_aux[36:3] : 34'd0;
    off_c_next  = 38'(off_3) - $signed({3'b0, off2});
    sens_c_next = 37'(sens_3) - $signed({3'b0, sens2});
  end

  // stage 5: D1 * SENS as two partial products
  logic [41:0]        plo_5;
  logic signed [43:0] phi_5;
  logic signed [37:0] off_5;
  logic signed [TEMP_W-1:0] temp_5;
  logic [41:0]        plo_next;
  logic signed [43:0] phi_next;
  logic signed [24:0] d1_s;
  logic signed [18:0] sens_hi;

  assign d1_s     = $signed({1'b0, d1_4});
  assign sens_hi  = $signed(sens_4[36:18]);
  assign plo_next = d1_4 * sens_4[17:0];
  assign phi_next = d1_s * sens_hi;

  // stage 6: combine partial products, divide by 2^21
  logic signed [39:0] x_6;
  logic signed [37:0] off_6;
  logic signed [TEMP_W-1:0] temp_6;
  logic signed [61:0] p_sum;
  logic signed [61:0] p_bias;
  logic signed [61:0] p_q;

  always_comb begin
    p_sum  = $signed({phi_5, 18'b0}) + $signed({20'b0, plo_5});
    p_bias = p_sum + (p_sum[61] ? 62'sd2097151 : 62'sd0);
    p_q    = p_bias >>> 21;
  end

  // stage 7: subtract OFF
  logic signed [40:0] y_7;
  logic signed [TEMP_W-1:0] temp_7;
  logic signed [40:0] y_next;

  assign y_next = 41'(x_6) - 41'(off_6);

  // stage 8: magnitude divided by 2^12, truncation toward zero kept by sign
  logic [28:0]        mag_8;
  logic               neg_8;
  logic signed [TEMP_W-1:0] temp_8;
  logic [40:0]        y_abs;

  assign y_abs = y_7[40] ? 41'(-y_7) : y_7;

  // stage 9: divide by ten through the reciprocal
  logic [60:0]        recip_9;
  logic               neg_9;
  logic signed [TEMP_W-1:0] temp_9;
  logic [60:0]        recip_next;

  assign recip_next = mag_8 * RECIP_TEN;

  // stage 10: restore sign; the pressure range stays well inside 32 bits
  logic signed [PRESS_W-1:0] press_10;
  logic signed [TEMP_W-1:0]  temp_10;
  logic [25:0]               quo;
  logic signed [PRESS_W-1:0] press_next;

  assign quo        = recip_9[60:RECIP_SHIFT];
  assign press_next = neg_9 ? -$signed({6'b0, quo}) : $signed({6'b0, quo});

  // pipeline data registers
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1_0 <= sample.raw_pressure;
      dt_0 <= dt_next;
    end
    if (adv[1]) begin
      d1_1     <= d1_0;
      prod_t_1 <= prod_t_next;
      prod_o_1 <= prod_o_next;
      prod_s_1 <= prod_s_next;
      dtsq_1   <= dtsq_full[47:0];
    end
    if (adv[2]) begin
      d1_2   <= d1_1;
      q_2    <= q_next;
      off_2  <= off_next;
      sens_2 <= sens_next;
      t2_2   <= t2_next;
    end
    if (adv[3]) begin
      d1_3   <= d1_2;
      neg_3  <= q_2[17];
      aux_3  <= aux_full[33:0];
      off_3  <= off_2;
      sens_3 <= sens_2;
      temp_3 <= temp_next;
    end
    if (adv[4]) begin
      d1_4   <= d1_3;
      off_4  <= off_c_next;
      sens_4 <= sens_c_next;
      temp_4 <= temp_3;
    end
    if (adv[5]) begin
      plo_5  <= plo_next;
      phi_5  <= phi_next;
      off_5  <= off_4;
      temp_5 <= temp_4;
    end
    if (adv[6]) begin
      x_6    <= p_q[39:0];
      off_6  <= off_5;
      temp_6 <= temp_5;
    end
    if (adv[7]) begin
      y_7    <= y_next;
      temp_7 <= temp_6;
    end
    if (adv[8]) begin
      mag_8  <= y_abs[40:12];
      neg_8  <= y_7[40];
      temp_8 <= temp_7;
    end
    if (adv[9]) begin
      recip_9 <= recip_next;
      neg_9   <= neg_8;
      temp_9  <= temp_8;
    end
    if (adv[10]) begin
      press_10 <= press_next;
      temp_10  <= temp_9;
    end
  end

  // result channel
  assign result.valid             = vld[NUM_STAGES-1];
  assign result.pressure          = press_10;
  assign result.temperature_centi = temp_10;

`ifndef SYNTHESIS
  // sample side only stalls when every stage is occupied
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> &vld)
    else $error("sample side stalled with an empty stage");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> vld == '0)
    else $error("pipeline not empty after reset");

  // occupancy follows the transfers on both channels
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(vld) ==
      $past($countones(vld)) + int'($past(in_xfer)) - int'($past(out_xfer)))
    else $error("item lost or duplicated inside the pipeline");

  // a held stage keeps its corrected offset
  a_hold_off: assert property (@(posedge clk) disable iff (rst)
    vld[4] && !adv[4] |=> $stable(off_4) && vld[4])
    else $error("stalled stage changed its data");
`endif

endmodule
